// ===== rtl/mpc_pkg.sv =====
`default_nettype none
package mpc_pkg;

    // Field widths
    localparam int unsigned LINE_W   = 6;
    localparam int unsigned PUSH_W   = 11;
    localparam int unsigned MS_W     = 13;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 11;

    // Saturation value of the millisecond counters
    localparam logic [MS_W-1:0] MS_MAX = '1;

    // Reset values of the configuration registers
    localparam logic [LINE_W-1:0] WATCHED_LINE_RST = LINE_W'(27);
    localparam logic [PUSH_W-1:0] PUSH_INTERVAL_RST = PUSH_W'(600);

    // Input item kinds
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_EDGE = 1'b1
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WATCHED_LINE  = 1'b0,
        CFG_PUSH_INTERVAL = 1'b1
    } t_cfg_idx;

    // Classification of a finished burst
    typedef enum logic [ACTION_W-1:0] {
        ACT_SINGLE = 2'd0,
        ACT_DOUBLE = 2'd1,
        ACT_TRIPLE = 2'd2,
        ACT_MORE   = 2'd3
    } t_action;

endpackage
`default_nettype wire

// ===== rtl/mpc_if.sv =====
`default_nettype none

// Input item channel: tick or falling edge on a line
interface mpc_in_if import mpc_pkg::*; ();
    logic               valid;
    logic               ready;
    t_opcode            opcode;
    logic [LINE_W-1:0]  line;

    modport source (output valid, opcode, line, input ready);
    modport sink   (input valid, opcode, line, output ready);
endinterface

// Result channel: one action per finished burst
interface mpc_out_if import mpc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_action action;

    modport source (output valid, action, input ready);
    modport sink   (input valid, action, output ready);
endinterface

// Configuration write channel
interface mpc_cfg_if import mpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/multi_press_classifier.sv =====
`default_nettype none
// Multi-press classifier for one watched input line.
// i_in carries input transactions: a 1 ms tick or a falling edge on a line.
// o_out carries one action per finished burst: single, double, triple, or
// four and more presses. i_cfg writes the watched line and the push interval
// P; it is always ready and must only be used while the block is idle.
// A transaction is captured into an input register; when the output register
// is free, the burst state is updated and any action is placed there.
// An action becomes valid on o_out at the edge that updates the burst state
// with the tick ending its burst.
// Throughput is one transaction per cycle while o_out is not stalled, set by the single update stage.
// When o_out stalls with an action held, the update stage stops: the input
// register keeps any transaction it holds, with i_in.ready low, until the action
// is taken, so nothing is lost or repeated.
// Reset clears the burst state, both valid flags, and loads watched line 27
// and interval 600 ms. No clearing pass is needed after reset.
// A burst ends on the tick that brings the time since its first press to 4*P.
// Presses count only when 0.5*P <= time since last press < 1.5*P.
module multi_press_classifier
    import mpc_pkg::*;
#(
    parameter int unsigned COUNT_MAX = 7
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mpc_in_if.sink    i_in,
    mpc_out_if.source o_out,
    mpc_cfg_if.sink   i_cfg
);

    localparam int unsigned CNT_W = $clog2(COUNT_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(COUNT_MAX);

    // Configuration registers
    logic [LINE_W-1:0] r_watched_line;
    logic [PUSH_W-1:0] r_push_interval;

    // Input register
    logic              r_in_valid;
    t_opcode           r_opcode;
    logic [LINE_W-1:0] r_line;

    // Burst state
    logic              r_active,     n_active;
    logic [CNT_W-1:0]  r_count,      n_count;
    logic [MS_W-1:0]   r_ms_last,    n_ms_last;
    logic [MS_W-1:0]   r_ms_first,   n_ms_first;

    // Output register
    logic              r_out_valid;
    t_action           r_action,     n_action;
    logic              n_emit;

    logic              out_free;
    logic              process;
    logic [MS_W:0]     twice_last;
    logic [MS_W:0]     lo_bound;
    logic [MS_W:0]     hi_bound;
    logic [MS_W-1:0]   limit;
    logic [MS_W-1:0]   inc_last;
    logic [MS_W-1:0]   inc_first;
    logic              in_window;

    assign out_free   = !r_out_valid || o_out.ready;
    assign process    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid  = r_out_valid;
    assign o_out.action = r_action;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watched_line  <= WATCHED_LINE_RST;
            r_push_interval <= PUSH_INTERVAL_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WATCHED_LINE:  r_watched_line  <= i_cfg.data[LINE_W-1:0];
                CFG_PUSH_INTERVAL: r_push_interval <= i_cfg.data[PUSH_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture input transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_opcode <= i_in.opcode;
            r_line   <= i_in.line;
        end
    end

    // Window bounds and burst length
    assign twice_last = {r_ms_last, 1'b0};
    assign lo_bound   = (MS_W+1)'(r_push_interval);
    assign hi_bound   = (MS_W+1)'(r_push_interval) + (MS_W+1)'({r_push_interval, 1'b0});
    assign limit      = MS_W'({r_push_interval, 2'b00});
    assign in_window  = (lo_bound <= twice_last) && (twice_last < hi_bound);
    assign inc_last   = (r_ms_last  == MS_MAX) ? MS_MAX : r_ms_last  + MS_W'(1);
    assign inc_first  = (r_ms_first == MS_MAX) ? MS_MAX : r_ms_first + MS_W'(1);

    // Update the burst state for one transaction
    always_comb begin
        n_active   = r_active;
        n_count    = r_count;
        n_ms_last  = r_ms_last;
        n_ms_first = r_ms_first;
        n_emit     = 1'b0;
        n_action   = ACT_SINGLE;

        if (r_count >= CNT_W'(4)) begin
            n_action = ACT_MORE;
        end else if (r_count == '0) begin
            n_action = ACT_SINGLE;
        end else begin
            n_action = t_action'(ACTION_W'(r_count - CNT_W'(1)));
        end

        if (r_opcode == OP_EDGE) begin
            if (r_line == r_watched_line) begin
                if (!r_active) begin
                    n_active   = 1'b1;
                    n_count    = CNT_W'(1);
                    n_ms_last  = '0;
                    n_ms_first = '0;
                end else if (in_window) begin
                    if (r_count < CNT_SAT) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    n_ms_last = '0;
                end
            end
        end else if (r_active) begin
            n_ms_last  = inc_last;
            n_ms_first = inc_first;
            if (inc_first >= limit) begin
                n_emit     = 1'b1;
                n_active   = 1'b0;
                n_count    = '0;
                n_ms_last  = '0;
                n_ms_first = '0;
            end
        end
    end

    // Advance burst state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_count    <= '0;
            r_ms_last  <= '0;
            r_ms_first <= '0;
        end else if (process) begin
            r_active   <= n_active;
            r_count    <= n_count;
            r_ms_last  <= n_ms_last;
            r_ms_first <= n_ms_first;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= process && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && n_emit) begin
            r_action <= n_action;
        end
    end

endmodule
`default_nettype wire
